@@ rtl/rcfc_pkg.sv @@
// Shared types, constants and codes of the command frame checker.
package rcfc_pkg;

  localparam int unsigned FRAME_BYTES = 8;

  // Frame byte positions.
  localparam int unsigned POS_MAGIC   = 0;
  localparam int unsigned POS_CMD     = 1;
  localparam int unsigned POS_FREQ_HI = 2;
  localparam int unsigned POS_FREQ_LO = 3;
  localparam int unsigned POS_MAG_HI  = 4;
  localparam int unsigned POS_MAG_LO  = 5;
  localparam int unsigned POS_CHECK   = 6;
  localparam int unsigned POS_LAST    = FRAME_BYTES - 1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ENV = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

  // Command codes.
  localparam logic [7:0] CMD_SET_REFERENCE = 8'h01;
  localparam logic [7:0] CMD_START_RUN     = 8'h02;
  localparam logic [7:0] CMD_STOP_RUN      = 8'h03;

  // Register byte addresses.
  localparam int unsigned ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_MAGIC    = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_TAIL     = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_MAX_FREQ = 4'h8;
  localparam logic [ADDR_W-1:0] ADDR_MAX_MAG  = 4'hC;

  // Register reset values.
  localparam logic [7:0]  MAGIC_RESET    = 8'hAA;
  localparam logic [7:0]  TAIL_RESET     = 8'h55;
  localparam logic [15:0] MAX_FREQ_RESET = 16'd65535;
  localparam logic [15:0] MAX_MAG_RESET  = 16'd5000;

  // Result packing in the output data word.
  localparam int unsigned OUT_W = 48;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic       tok;  // this cell owns the current byte position
    logic [7:0] acc;  // XOR of the frame bytes up to and including this cell
  } rcfc_link_t;

endpackage

@@ rtl/rcfc_cell.sv @@
// One byte-position cell of the frame checker chain.
module rcfc_cell
  import rcfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,     // a byte transaction completes this cycle
  input  logic       start_i,   // the byte is flagged as frame byte 0
  input  logic       first_i,   // tied high on the cell of byte 0
  input  logic [7:0] byte_i,
  input  logic [7:0] cmp_i,     // value the captured byte is matched against
  input  rcfc_link_t link_i,
  output rcfc_link_t link_o,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic       hold_q, hold_d;
  logic       tok;
  logic       eff_tok;
  logic [7:0] byte_q;
  logic [7:0] acc_q;
  logic       match_q;

  // The first cell stores its token inverted so that reset leaves it owning.
  assign tok     = first_i ? ~hold_q : hold_q;
  assign eff_tok = start_i ? first_i : tok;
  assign hold_d  = first_i ? ~link_i.tok : link_i.tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (adv_i) begin
      hold_q <= hold_d;
      if (eff_tok) begin
        match_q <= (byte_i == cmp_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && eff_tok) begin
      byte_q <= byte_i;
      acc_q  <= link_i.acc ^ byte_i;
    end
  end

  assign link_o.tok = eff_tok;
  assign link_o.acc = acc_q;
  assign byte_o     = byte_q;
  assign match_o    = match_q;

endmodule

@@ rtl/reference_command_frame_checker.sv @@
// Top level of the command frame checker: cell chain, limit checks and result register.
//
// Usage: received frame bytes enter on the slave stream, one byte per
// transaction, with s_axis_tuser high on a byte that must be taken as frame
// byte 0. The byte position otherwise steps through the eight frame bytes
// and wraps. Each position is one cell of a chain; a token moves from cell
// to cell with every byte, and the owning cell captures the byte and its
// running XOR, handing the XOR to its neighbor. On the eighth byte one
// result transaction is formed and held in the output register: status,
// frequency and magnitude in hundredths, command byte, apply flag and the
// run flag after the frame. A frame cut short by a start flag gives none.
// The result is registered and appears in the cycle after the last byte is
// accepted. One byte per cycle while input ready is high; it drops only when a
// result is still waiting in the output register, the master side is stalled,
// and the next byte would close another frame.
// Reset (asynchronous, active low) places the chain at byte 0, stops the
// modulator run flag and loads the register defaults. The APB port writes
// the magic byte, tail byte and the two limits; pready is always high.
module reference_command_frame_checker
  import rcfc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Slave stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  logic              s_axis_tuser,   // [0] frame_start
  // Master stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [17:2] freq_hundredths, [33:18] mag_hundredths,
  // [41:34] command_code, [42] apply_reference, [43] modulator_running,
  // [47:44] zero
  output logic [OUT_W-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [7:0]  magic_q;
  logic [7:0]  tail_q;
  logic [15:0] max_freq_q;
  logic [15:0] max_mag_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= MAGIC_RESET;
      tail_q     <= TAIL_RESET;
      max_freq_q <= MAX_FREQ_RESET;
      max_mag_q  <= MAX_MAG_RESET;
    end else if (cfg_we) begin
      unique case (paddr)
        ADDR_MAGIC:    magic_q    <= pwdata[7:0];
        ADDR_TAIL:     tail_q     <= pwdata[7:0];
        ADDR_MAX_FREQ: max_freq_q <= pwdata[15:0];
        ADDR_MAX_MAG:  max_mag_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_MAGIC:    prdata = {24'd0, magic_q};
      ADDR_TAIL:     prdata = {24'd0, tail_q};
      ADDR_MAX_FREQ: prdata = {16'd0, max_freq_q};
      ADDR_MAX_MAG:  prdata = {16'd0, max_mag_q};
      default:       prdata = 32'd0;
    endcase
  end

  // Cell chain, one cell per frame byte position.
  rcfc_link_t link      [FRAME_BYTES];
  logic [7:0] cell_byte [FRAME_BYTES];
  logic       cell_match[FRAME_BYTES];
  logic       adv;
  logic       out_valid_q;

  // A pending result blocks only the byte that would close the next frame.
  assign s_axis_tready = !(out_valid_q && !m_axis_tready && link[POS_LAST].tok);
  assign adv           = s_axis_tvalid && s_axis_tready;

  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    rcfc_link_t link_in;
    logic [7:0] cmp;

    if (k == 0) begin : g_head
      // The last cell hands its token back to the first; the XOR restarts.
      assign link_in.tok = link[FRAME_BYTES-1].tok;
      assign link_in.acc = 8'd0;
    end else begin : g_body
      assign link_in = link[k-1];
    end

    if (k == POS_MAGIC) begin : g_cmp_magic
      assign cmp = magic_q;
    end else if (k == POS_CHECK) begin : g_cmp_check
      assign cmp = link[k-1].acc;
    end else begin : g_cmp_none
      assign cmp = 8'd0;
    end

    rcfc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .start_i (s_axis_tuser),
      .first_i (k == 0),
      .byte_i  (s_axis_tdata),
      .cmp_i   (cmp),
      .link_i  (link_in),
      .link_o  (link[k]),
      .byte_o  (cell_byte[k]),
      .match_o (cell_match[k])
    );
  end

  // Frame evaluation on the last byte.
  logic [15:0] freq;
  logic [15:0] mag;
  logic [7:0]  cmd;
  logic        fire;
  logic        env_ok;
  logic        range_bad;
  logic [1:0]  status;
  logic        apply;
  logic        run_q, run_d;

  assign freq = {cell_byte[POS_FREQ_HI], cell_byte[POS_FREQ_LO]};
  assign mag  = {cell_byte[POS_MAG_HI], cell_byte[POS_MAG_LO]};
  assign cmd  = cell_byte[POS_CMD];
  assign fire = adv && link[POS_LAST].tok;

  assign env_ok    = cell_match[POS_MAGIC] && cell_match[POS_CHECK] &&
                     (s_axis_tdata == tail_q);
  assign range_bad = (freq > max_freq_q) || (mag > max_mag_q);

  always_comb begin
    run_d = run_q;
    apply = 1'b0;
    priority if (!env_ok) begin
      status = STATUS_BAD_ENV;
    end else if (range_bad) begin
      status = STATUS_RANGE;
    end else begin
      apply = 1'b1;
      if (cmd == CMD_SET_REFERENCE || cmd == CMD_START_RUN) begin
        run_d  = 1'b1;
        status = STATUS_OK;
      end else if (cmd == CMD_STOP_RUN) begin
        run_d  = 1'b0;
        status = STATUS_OK;
      end else begin
        status = STATUS_UNKNOWN;
      end
    end
  end

  // Output register.
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_q       <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        run_q       <= run_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {4'd0, run_d, apply, cmd, mag, freq, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/rcfc_checker.sv @@
// Port-level assertions of the command frame checker and their bind.
module rcfc_checker
  import rcfc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             pready
);

  logic [1:0] st;
  assign st = m_axis_tdata[1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_apply_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[42] == ((st == STATUS_OK) || (st == STATUS_UNKNOWN))))
    else $error("apply flag disagrees with status");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == STATUS_OK) && (m_axis_tdata[41:34] == CMD_STOP_RUN)
      |-> !m_axis_tdata[43])
    else $error("stop command left run flag set");

  a_start_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == STATUS_OK) &&
      ((m_axis_tdata[41:34] == CMD_SET_REFERENCE) ||
       (m_axis_tdata[41:34] == CMD_START_RUN))
      |-> m_axis_tdata[43])
    else $error("run command left run flag clear");

  a_pad_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && (!m_axis_tvalid || (m_axis_tdata[47:44] == 4'd0)))
    else $error("pready low or padding bits set");

endmodule

bind reference_command_frame_checker rcfc_checker u_rcfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
